@@ rtl/sfha_pkg.sv @@
// Shared types, constants and helpers of the segregated-fit heap allocator.
`default_nettype none
package sfha_pkg;

  localparam int unsigned HeapBytesDef = 1048576;
  localparam int unsigned NumClasses   = 15;
  localparam int unsigned WordW        = 32;
  localparam int unsigned PortAddrW    = 20;
  localparam int unsigned ReqW         = 20;
  localparam int unsigned CfgW         = 21;
  localparam int unsigned ClassW       = 4;
  localparam logic [WordW-1:0] MinBlock = 32'd24;
  localparam logic [WordW-1:0] InitGrow = 32'd4096;
  localparam logic [CfgW-1:0]  ExtReset = 21'd4096;

  typedef logic [WordW-1:0] word_t;

  localparam word_t ClassLimit [14] = '{
    32'd24, 32'd48, 32'd72, 32'd96, 32'd120, 32'd240, 32'd480, 32'd960,
    32'd1920, 32'd3840, 32'd7680, 32'd15360, 32'd30720, 32'd61440
  };

  typedef enum logic [5:0] {
    S_IDLE, S_INIT0, S_INIT1, S_INIT2, S_INIT3, S_DISPATCH,
    S_AL0, S_FF_CLASS, S_FF_NODE, S_FF_CHK, S_FF_NEXT, S_AL_EXT, S_AL_EXD,
    S_PL0, S_PL1, S_PL2, S_PL3, S_PL4, S_PL5, S_PL6, S_PL_NS, S_AL_OK,
    S_FR0, S_FR1, S_FR2, S_FR3, S_FR4, S_FR5, S_FR_OK,
    S_EX0, S_EX1, S_EX2, S_EX3, S_EX4, S_EX5,
    S_MG0, S_MG1, S_MG2, S_MG3, S_MG4, S_MG5, S_MG6,
    S_MG_D1, S_MG_D2, S_MG_D3, S_MG_T1, S_MG_T2,
    S_MG_R0, S_MG_R1, S_MG_R2, S_MG_R3, S_MG_INS,
    S_LI0, S_LI1, S_LI2,
    S_LD0, S_LD1, S_LD2, S_LD3, S_LD4,
    S_DONE
  } state_e;

  // Which neighbors are free when merging.
  typedef enum logic [1:0] {
    MC_NEXT_FREE, MC_PREV_FREE, MC_BOTH_FREE
  } merge_case_e;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_e;

  function automatic word_t tag_size(word_t w);
    return {w[WordW-1:3], 3'b000};
  endfunction

  function automatic logic [ClassW-1:0] class_of(word_t s);
    logic [ClassW-1:0] c;
    c = ClassW'(14);
    for (int i = 13; i >= 0; i--) begin
      if (s <= ClassLimit[i]) c = ClassW'(i);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

@@ rtl/sfha_ram.sv @@
// Generic single-port RAM with registered read data.
`default_nettype none
module sfha_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule
`default_nettype wire

@@ rtl/segregated_fit_heap_allocator.sv @@
// Top level of the segregated-fit heap allocator with boundary tags.
`default_nettype none
// Each transfer on the input channel is one allocate or free, answered by one
// result transfer. The heap lives in a single-port word RAM with registered read
// data and every header, footer and list link goes through that port one word
// per cycle, so the time an item takes depends on the data: a free takes longer
// when it merges with free neighbors, and an allocate takes longer with each
// list node visited and size class scanned, for the split, and when the heap
// must grow. The very first item also lays down the heap start and a first
// 4096-byte free block. The next item is taken once the current one has
// finished; a finished result may wait in the output register.
module segregated_fit_heap_allocator import sfha_pkg::*; #(
  parameter int unsigned HEAP_BYTES = HeapBytesDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CfgW-1:0]      cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 action_i,
  input  wire logic [ReqW-1:0]      request_size_i,
  input  wire logic [PortAddrW-1:0] block_address_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [PortAddrW-1:0]      payload_address_o,
  output logic                      success_o
);

  localparam int unsigned RamDepth  = HEAP_BYTES / 4;
  localparam int unsigned RamAw     = $clog2(RamDepth);
  localparam int unsigned WalkLimit = HEAP_BYTES / 24 + NumClasses;
  localparam int unsigned StepW     = $clog2(WalkLimit + 2);
  localparam word_t HeapTop = word_t'(HEAP_BYTES);

  state_e state_q, state_d, subret_q, subret_d, mgret_q, mgret_d, exret_q, exret_d;
  merge_case_e mcase_q, mcase_d;
  logic act_q, act_d;
  logic [ReqW-1:0] req_q, req_d;
  logic [PortAddrW-1:0] addr_q, addr_d;
  word_t bp_q, bp_d, prv_q, prv_d, nxt_q, nxt_d, size_q, size_d;
  word_t bsz_q, bsz_d, csz_q, csz_d, asize_q, asize_d;
  word_t lp_q, lp_d, ls_q, ls_d, pv_q, pv_d, nx_q, nx_d, ffp_q, ffp_d;
  word_t brk_q, brk_d, ext_q, ext_d, hdr_q, hdr_d;
  logic pu_q, pu_d, exok_q, exok_d, init_q, init_d;
  logic [ClassW-1:0] ldc_q, ldc_d, ffc_q, ffc_d;
  logic [StepW-1:0] steps_q, steps_d;
  logic [CfgW-1:0] extend_q;
  logic [PortAddrW-1:0] res_addr_q, res_addr_d, out_addr_q, out_addr_d;
  logic res_ok_q, res_ok_d, out_ok_q, out_ok_d, outv_q, outv_d;
  word_t heads_q [NumClasses];

  logic mem_we, rd_oob_q, inrange, head_we;
  word_t mem_addr, mem_wdata, rd, head_rd, head_wval, ext_max, ext_round;
  logic [ClassW-1:0] head_ridx, head_widx;
  logic [RamAw-1:0] ram_addr;
  word_t ram_rdata;
  logic [WordW:0] free_end;

  assign inrange  = (mem_addr < HeapTop);
  assign ram_addr = mem_addr[RamAw+1:2];
  assign rd       = rd_oob_q ? '0 : ram_rdata;
  assign head_rd  = heads_q[head_ridx];
  assign ext_max  = (asize_q > word_t'(extend_q)) ? asize_q : word_t'(extend_q);
  assign ext_round = ({2'b00, ext_q[WordW-1:2]} + {31'd0, ext_q[2]}) << 2;
  assign free_end = {1'b0, word_t'(addr_q)} + {1'b0, tag_size(rd)};

  sfha_ram #(.Width(WordW), .Depth(RamDepth)) u_heap_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we && inrange),
    .addr_i  (ram_addr),
    .wdata_i (mem_wdata),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o        = (state_q == S_IDLE);
  assign out_valid_o       = outv_q;
  assign payload_address_o = out_addr_q;
  assign success_o         = out_ok_q;

  always_comb begin
    state_d = state_q;  subret_d = subret_q; mgret_d = mgret_q; exret_d = exret_q;
    mcase_d = mcase_q;  act_d = act_q;       req_d = req_q;     addr_d = addr_q;
    bp_d = bp_q;   prv_d = prv_q; nxt_d = nxt_q; size_d = size_q;
    bsz_d = bsz_q; csz_d = csz_q; asize_d = asize_q;
    lp_d = lp_q;   ls_d = ls_q;   pv_d = pv_q;   nx_d = nx_q;   ffp_d = ffp_q;
    brk_d = brk_q; ext_d = ext_q; hdr_d = hdr_q; pu_d = pu_q;
    exok_d = exok_q; init_d = init_q; ldc_d = ldc_q; ffc_d = ffc_q; steps_d = steps_q;
    res_addr_d = res_addr_q; res_ok_d = res_ok_q;
    out_addr_d = out_addr_q; out_ok_d = out_ok_q;
    outv_d = outv_q && !out_ready_i;
    mem_we = 1'b0; mem_addr = '0; mem_wdata = '0;
    head_we = 1'b0; head_widx = '0; head_wval = '0;
    head_ridx = class_of(ls_q);

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act_d = action_i; req_d = request_size_i; addr_d = block_address_i;
          res_addr_d = '0; res_ok_d = 1'b0;
          state_d = init_q ? S_DISPATCH : S_INIT0;
        end
      end
      // Heap start: pad word, 8-byte allocated block, epilogue.
      S_INIT0: begin
        init_d = 1'b1; brk_d = 32'd16;
        mem_we = 1'b1; mem_addr = 32'd0; mem_wdata = '0; state_d = S_INIT1;
      end
      S_INIT1: begin
        mem_we = 1'b1; mem_addr = 32'd4; mem_wdata = 32'd9; state_d = S_INIT2;
      end
      S_INIT2: begin
        mem_we = 1'b1; mem_addr = 32'd8; mem_wdata = 32'd9; state_d = S_INIT3;
      end
      S_INIT3: begin
        mem_we = 1'b1; mem_addr = 32'd12; mem_wdata = 32'd1;
        ext_d = InitGrow; exret_d = S_DISPATCH; state_d = S_EX0;
      end
      S_DISPATCH: state_d = (act_q == ACT_FREE) ? S_FR0 : S_AL0;

      // Allocate
      S_AL0: begin
        if (req_q == '0) begin
          state_d = S_DONE;
        end else begin
          asize_d = (req_q <= 20'd16) ? MinBlock
                  : ((word_t'(req_q) + 32'd7) & ~32'd7) + 32'd8;
          ffc_d = class_of(asize_d);
          steps_d = '0;
          state_d = S_FF_CLASS;
        end
      end
      S_FF_CLASS: begin
        head_ridx = (ffc_q == ClassW'(NumClasses)) ? '0 : ffc_q;
        if (ffc_q == ClassW'(NumClasses)) begin
          state_d = S_AL_EXT;
        end else if (head_rd == '0) begin
          ffc_d = ffc_q + 1'b1;
        end else begin
          ffp_d = head_rd; state_d = S_FF_NODE;
        end
      end
      S_FF_NODE: begin
        steps_d = steps_q + 1'b1;
        if (steps_d > StepW'(WalkLimit)) begin
          state_d = S_AL_EXT;
        end else begin
          mem_addr = ffp_q - 32'd4; state_d = S_FF_CHK;
        end
      end
      S_FF_CHK: begin
        if (asize_q <= tag_size(rd)) begin
          bp_d = ffp_q; state_d = S_PL0;
        end else begin
          mem_addr = ffp_q; state_d = S_FF_NEXT;
        end
      end
      S_FF_NEXT: begin
        if (rd == '0) begin
          ffc_d = ffc_q + 1'b1; state_d = S_FF_CLASS;
        end else begin
          ffp_d = rd; state_d = S_FF_NODE;
        end
      end
      S_AL_EXT: begin
        ext_d = ext_max; exret_d = S_AL_EXD; state_d = S_EX0;
      end
      S_AL_EXD: state_d = exok_q ? S_PL0 : S_DONE;

      // Place: mark allocated, split off a free remainder when large enough.
      S_PL0: begin
        mem_addr = bp_q - 32'd4; state_d = S_PL1;
      end
      S_PL1: begin
        csz_d = tag_size(rd);
        lp_d = bp_q; subret_d = S_PL2; state_d = S_LD0;
      end
      S_PL2: begin
        mem_we = 1'b1; mem_addr = bp_q - 32'd4;
        if (csz_q >= asize_q && (csz_q - asize_q) >= MinBlock) begin
          mem_wdata = asize_q | 32'd1; state_d = S_PL3;
        end else begin
          mem_wdata = csz_q | 32'd1; state_d = S_PL_NS;
        end
      end
      S_PL3: begin
        mem_we = 1'b1; mem_addr = bp_q + asize_q - 32'd8;
        mem_wdata = asize_q | 32'd1; state_d = S_PL4;
      end
      S_PL4: begin
        mem_we = 1'b1; mem_addr = bp_q + asize_q - 32'd4;
        mem_wdata = csz_q - asize_q; state_d = S_PL5;
      end
      S_PL5: begin
        mem_we = 1'b1; mem_addr = bp_q + csz_q - 32'd8;
        mem_wdata = csz_q - asize_q; state_d = S_PL6;
      end
      S_PL6: begin
        lp_d = bp_q + asize_q; ls_d = csz_q - asize_q;
        subret_d = S_AL_OK; state_d = S_LI0;
      end
      S_PL_NS: begin
        mem_we = 1'b1; mem_addr = bp_q + csz_q - 32'd8;
        mem_wdata = csz_q | 32'd1; state_d = S_AL_OK;
      end
      S_AL_OK: begin
        res_addr_d = bp_q[PortAddrW-1:0]; res_ok_d = 1'b1; state_d = S_DONE;
      end

      // Free: validate tags, mark free, insert, merge.
      S_FR0: begin
        if (addr_q == '0 || addr_q[2:0] != 3'd0 || addr_q < 20'd16) begin
          state_d = S_DONE;
        end else begin
          mem_addr = word_t'(addr_q) - 32'd4; state_d = S_FR1;
        end
      end
      S_FR1: begin
        hdr_d = rd; size_d = tag_size(rd);
        if (!rd[0] || tag_size(rd) < MinBlock || free_end > {1'b0, brk_q}) begin
          state_d = S_DONE;
        end else begin
          mem_addr = word_t'(addr_q) + tag_size(rd) - 32'd8; state_d = S_FR2;
        end
      end
      S_FR2: begin
        if (rd != hdr_q) begin
          state_d = S_DONE;
        end else begin
          mem_we = 1'b1; mem_addr = word_t'(addr_q) - 32'd4; mem_wdata = size_q;
          state_d = S_FR3;
        end
      end
      S_FR3: begin
        mem_we = 1'b1; mem_addr = word_t'(addr_q) + size_q - 32'd8; mem_wdata = size_q;
        state_d = S_FR4;
      end
      S_FR4: begin
        lp_d = word_t'(addr_q); ls_d = size_q; subret_d = S_FR5; state_d = S_LI0;
      end
      S_FR5: begin
        bp_d = word_t'(addr_q); mgret_d = S_FR_OK; state_d = S_MG0;
      end
      S_FR_OK: begin
        res_ok_d = 1'b1; state_d = S_DONE;
      end

      // Extend the heap by a free block, if it fits, and merge it backward.
      S_EX0: begin
        if ({1'b0, brk_q} + {1'b0, ext_round} > {1'b0, HeapTop}) begin
          exok_d = 1'b0; state_d = exret_q;
        end else begin
          exok_d = 1'b1; bp_d = brk_q; size_d = ext_round;
          brk_d = brk_q + ext_round; state_d = S_EX1;
        end
      end
      S_EX1: begin
        mem_we = 1'b1; mem_addr = bp_q - 32'd4; mem_wdata = size_q; state_d = S_EX2;
      end
      S_EX2: begin
        mem_we = 1'b1; mem_addr = bp_q + size_q - 32'd8; mem_wdata = size_q;
        state_d = S_EX3;
      end
      S_EX3: begin
        mem_we = 1'b1; mem_addr = bp_q + size_q - 32'd4; mem_wdata = 32'd1;
        state_d = S_EX4;
      end
      S_EX4: begin
        lp_d = bp_q; ls_d = size_q; subret_d = S_EX5; state_d = S_LI0;
      end
      S_EX5: begin
        mgret_d = exret_q; state_d = S_MG0;
      end

      // Merge with free neighbors; result block in bp.
      S_MG0: begin
        mem_addr = bp_q - 32'd8; state_d = S_MG1;
      end
      S_MG1: begin
        prv_d = bp_q - tag_size(rd); mem_addr = bp_q - 32'd4; state_d = S_MG2;
      end
      S_MG2: begin
        bsz_d = tag_size(rd); nxt_d = bp_q + tag_size(rd);
        mem_addr = prv_q - 32'd4; state_d = S_MG3;
      end
      S_MG3: begin
        csz_d = tag_size(rd); mem_addr = prv_q + tag_size(rd) - 32'd8; state_d = S_MG4;
      end
      S_MG4: begin
        pu_d = rd[0]; mem_addr = nxt_q - 32'd4; state_d = S_MG5;
      end
      S_MG5: begin
        if (pu_q && rd[0]) begin
          state_d = mgret_q;
        end else if (pu_q) begin
          size_d = bsz_q + tag_size(rd); mcase_d = MC_NEXT_FREE; state_d = S_MG_D1;
        end else if (rd[0]) begin
          size_d = bsz_q + csz_q; mcase_d = MC_PREV_FREE; state_d = S_MG_D1;
        end else begin
          mcase_d = MC_BOTH_FREE;
          mem_addr = nxt_q + tag_size(rd) - 32'd8; state_d = S_MG6;
        end
      end
      S_MG6: begin
        size_d = bsz_q + csz_q + tag_size(rd); state_d = S_MG_D1;
      end
      S_MG_D1: begin
        lp_d = (mcase_q == MC_NEXT_FREE) ? bp_q : prv_q;
        subret_d = S_MG_D2; state_d = S_LD0;
      end
      S_MG_D2: begin
        lp_d = (mcase_q == MC_PREV_FREE) ? bp_q : nxt_q;
        subret_d = (mcase_q == MC_BOTH_FREE) ? S_MG_D3 : S_MG_T1;
        state_d = S_LD0;
      end
      S_MG_D3: begin
        lp_d = bp_q; subret_d = S_MG_R0; state_d = S_LD0;
      end
      S_MG_T1: begin
        if (mcase_q == MC_PREV_FREE) bp_d = prv_q;
        mem_we = 1'b1; mem_addr = bp_d - 32'd4; mem_wdata = size_q; state_d = S_MG_T2;
      end
      S_MG_T2: begin
        mem_we = 1'b1; mem_addr = bp_q + size_q - 32'd8; mem_wdata = size_q;
        state_d = S_MG_INS;
      end
      S_MG_R0: begin
        mem_we = 1'b1; mem_addr = prv_q - 32'd4; mem_wdata = size_q; state_d = S_MG_R1;
      end
      // Re-read the middle header to locate the far footer.
      S_MG_R1: begin
        mem_addr = bp_q - 32'd4; state_d = S_MG_R2;
      end
      S_MG_R2: begin
        nxt_d = bp_q + tag_size(rd); mem_addr = nxt_d - 32'd4; state_d = S_MG_R3;
      end
      S_MG_R3: begin
        mem_we = 1'b1; mem_addr = nxt_q + tag_size(rd) - 32'd8; mem_wdata = size_q;
        bp_d = prv_q; state_d = S_MG_INS;
      end
      S_MG_INS: begin
        lp_d = bp_q; ls_d = size_q; subret_d = mgret_q; state_d = S_LI0;
      end

      // List insert at head of class of ls.
      S_LI0: begin
        mem_we = 1'b1; mem_addr = lp_q; mem_wdata = head_rd; state_d = S_LI1;
      end
      S_LI1: begin
        mem_we = 1'b1; mem_addr = lp_q + 32'd8; mem_wdata = '0; state_d = S_LI2;
      end
      S_LI2: begin
        if (head_rd != '0) begin
          mem_we = 1'b1; mem_addr = head_rd + 32'd8; mem_wdata = lp_q;
        end
        head_we = 1'b1; head_widx = class_of(ls_q); head_wval = lp_q;
        state_d = subret_q;
      end

      // List delete of node lp.
      S_LD0: begin
        mem_addr = lp_q - 32'd4; state_d = S_LD1;
      end
      S_LD1: begin
        ldc_d = class_of(tag_size(rd)); mem_addr = lp_q + 32'd8; state_d = S_LD2;
      end
      S_LD2: begin
        pv_d = rd; mem_addr = lp_q; state_d = S_LD3;
      end
      S_LD3: begin
        nx_d = rd;
        if (pv_q != '0) begin
          mem_we = 1'b1; mem_addr = pv_q; mem_wdata = rd;
        end else begin
          head_we = 1'b1; head_widx = ldc_q; head_wval = rd;
        end
        state_d = S_LD4;
      end
      S_LD4: begin
        if (nx_q != '0) begin
          mem_we = 1'b1; mem_addr = nx_q + 32'd8; mem_wdata = pv_q;
        end
        state_d = subret_q;
      end

      // Hold the result until the output register is free.
      S_DONE: begin
        if (!outv_q || out_ready_i) begin
          outv_d = 1'b1; out_addr_d = res_addr_q; out_ok_d = res_ok_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; subret_q <= S_IDLE; mgret_q <= S_IDLE; exret_q <= S_IDLE;
      mcase_q <= MC_NEXT_FREE;
      init_q <= 1'b0; brk_q <= '0; outv_q <= 1'b0; extend_q <= ExtReset;
      rd_oob_q <= 1'b0;
      for (int i = 0; i < NumClasses; i++) heads_q[i] <= '0;
    end else begin
      state_q <= state_d; subret_q <= subret_d; mgret_q <= mgret_d;
      exret_q <= exret_d; mcase_q <= mcase_d;
      init_q <= init_d; brk_q <= brk_d; outv_q <= outv_d;
      rd_oob_q <= !inrange;
      if (cfg_we_i) extend_q <= cfg_data_i;
      if (head_we) heads_q[head_widx] <= head_wval;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= act_d; req_q <= req_d; addr_q <= addr_d;
    bp_q <= bp_d; prv_q <= prv_d; nxt_q <= nxt_d; size_q <= size_d;
    bsz_q <= bsz_d; csz_q <= csz_d; asize_q <= asize_d;
    lp_q <= lp_d; ls_q <= ls_d; pv_q <= pv_d; nx_q <= nx_d; ffp_q <= ffp_d;
    ext_q <= ext_d; hdr_q <= hdr_d; pu_q <= pu_d; exok_q <= exok_d;
    ldc_q <= ldc_d; ffc_q <= ffc_d; steps_q <= steps_d;
    res_addr_q <= res_addr_d; res_ok_q <= res_ok_d;
    out_addr_q <= out_addr_d; out_ok_q <= out_ok_d;
  end

`ifndef ASSERT_OFF
  a_brk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    brk_q <= HeapTop && brk_q[2:0] == 3'd0)
    else $error("heap break out of range or misaligned");
  a_init_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> ##1 init_q)
    else $error("heap not started after first transfer");
  a_fail_no_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !success_o |-> payload_address_o == '0)
    else $error("failed result carries an address");
  a_free_no_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FR_OK |=> res_addr_q == '0 && res_ok_q)
    else $error("free result malformed");
`endif

endmodule
`default_nettype wire
